### rtl/core/xlb_pkg.sv
// xlb_pkg: constants, command codes and controller/datapath interface types
// for the XOR linear basis engine. No dependencies.

package xlb_pkg;

	localparam int BITS   = 30;          // word width and number of basis rows
	localparam int IDX_W  = 5;           // row index width
	localparam int RANK_W = 5;
	localparam int DEP_W  = 6;
	localparam int K_W    = 31;          // index and answer width
	localparam int CMD_W  = 3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BITS - 1);
	localparam logic [DEP_W-1:0] DEP_SAT  = DEP_W'(61);
	localparam logic [DEP_W-1:0] DEP_MAXSHIFT = DEP_W'(K_W);

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT   = 3'd0,
		CMD_CONTAINS = 3'd1,
		CMD_MAX      = 3'd2,
		CMD_KTH      = 3'd3,
		CMD_KTH_DUP  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_UPDATE,
		ST_MAX,
		ST_KTH,
		ST_COMMIT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_REDUCE,
		OP_UPDATE,
		OP_MAX,
		OP_KTH,
		OP_COMMIT,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [IDX_W-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

### rtl/core/xlb_ctrl.sv
// xlb_ctrl: basis engine sequencer, depends on xlb_pkg; walks the row index
// and issues one datapath operation per cycle, but holds in done for output.

module xlb_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [xlb_pkg::CMD_W-1:0] command,
	input  xlb_pkg::dp_sts_t        sts,
	output xlb_pkg::dp_cmd_t        dcmd
);
	import xlb_pkg::*;

	state_t           state_q, state_d;
	cmd_t             cmd_in;
	cmd_t             cmd_q;
	logic [IDX_W-1:0] cnt_q;
	logic             accept;

	assign cmd_in = cmd_t'(command);
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_INSERT;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cmd_q <= cmd_in;
				cnt_q <= (cmd_in inside {CMD_KTH, CMD_KTH_DUP}) ? '0 : LAST_IDX;
			end else begin
				case (state_q)
					ST_REDUCE, ST_UPDATE, ST_MAX: begin
						cnt_q <= (cnt_q == '0) ? LAST_IDX : cnt_q - IDX_W'(1);
					end
					ST_KTH: begin
						cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + IDX_W'(1);
					end
					default: begin
						cnt_q <= cnt_q;
					end
				endcase
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (cmd_in)
						CMD_INSERT, CMD_CONTAINS: state_d = ST_REDUCE;
						CMD_MAX:                  state_d = ST_MAX;
						CMD_KTH, CMD_KTH_DUP:     state_d = ST_KTH;
						default:                  state_d = ST_DONE;
					endcase
				end
			end
			ST_REDUCE: begin
				if (cnt_q == '0)
					state_d = (cmd_q == CMD_INSERT) ? ST_UPDATE : ST_DONE;
			end
			ST_UPDATE: begin
				if (cnt_q == '0)
					state_d = ST_COMMIT;
			end
			ST_MAX: begin
				if (cnt_q == '0)
					state_d = ST_DONE;
			end
			ST_KTH: begin
				if (cnt_q == LAST_IDX)
					state_d = ST_DONE;
			end
			ST_COMMIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		dcmd.op  = OP_NOP;
		dcmd.idx = cnt_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					dcmd.op = OP_LOAD;
			end
			ST_REDUCE: dcmd.op = OP_REDUCE;
			ST_UPDATE: dcmd.op = OP_UPDATE;
			ST_MAX:    dcmd.op = OP_MAX;
			ST_KTH:    dcmd.op = OP_KTH;
			ST_COMMIT: dcmd.op = OP_COMMIT;
			ST_DONE: begin
				if (sts.out_free)
					dcmd.op = OP_EMIT;
			end
			default: dcmd.op = OP_NOP;
		endcase
	end

endmodule

### rtl/core/xlb_dpath.sv
// xlb_dpath: basis rows, working word, rank, dependent count and the
// result register. Depends on xlb_pkg.

module xlb_dpath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  xlb_pkg::dp_cmd_t        dcmd,
	output xlb_pkg::dp_sts_t        sts,
	input  logic [xlb_pkg::CMD_W-1:0] command,
	input  logic [xlb_pkg::BITS-1:0]  value,
	input  logic [xlb_pkg::K_W-1:0]   index,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [xlb_pkg::K_W-1:0] answer,
	output logic                    flag
);
	import xlb_pkg::*;

	logic [BITS-1:0]   rows_q [BITS];
	logic [BITS-1:0]   x_q;
	logic [K_W-1:0]    k_q;
	logic [IDX_W-1:0]  p_q;
	logic              p_valid_q;
	logic              oor_q;
	cmd_t              cmd_q;
	logic [RANK_W-1:0] rank_q;
	logic [DEP_W-1:0]  dep_q;
	logic [K_W-1:0]    ans_q;
	logic              flag_q;
	logic              out_valid_q;

	logic [BITS-1:0]   row_sel;
	logic              row_nz;
	cmd_t              cmd_in;
	logic [K_W-1:0]    k_eff;
	logic [K_W-1:0]    rank_mask;
	logic [K_W-1:0]    ans_d;
	logic              flag_d;

	assign row_sel = rows_q[dcmd.idx];
	assign row_nz  = (row_sel != '0);
	assign cmd_in  = cmd_t'(command);

	// duplicate-counting kth shifts k by the dependent count first
	always_comb begin
		k_eff = index;
		if (cmd_in == CMD_KTH_DUP)
			k_eff = (dep_q >= DEP_MAXSHIFT) ? '0 : (index >> dep_q);
		rank_mask = (K_W'(1) << rank_q) - K_W'(1);
	end

	always_comb begin
		ans_d  = '0;
		flag_d = 1'b0;
		case (cmd_q)
			CMD_INSERT:   flag_d = p_valid_q;
			CMD_CONTAINS: flag_d = (x_q == '0);
			CMD_MAX:      ans_d  = K_W'(x_q);
			CMD_KTH, CMD_KTH_DUP: ans_d = oor_q ? '1 : K_W'(x_q);
			default: begin
				ans_d  = '0;
				flag_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < BITS; r++)
				rows_q[r] <= '0;
			rank_q      <= '0;
			dep_q       <= '0;
			out_valid_q <= 1'b0;
			p_valid_q   <= 1'b0;
			cmd_q       <= CMD_INSERT;
		end else begin
			if (dcmd.op == OP_EMIT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (dcmd.op)
				OP_LOAD: begin
					cmd_q     <= cmd_in;
					p_valid_q <= 1'b0;
				end
				OP_REDUCE: begin
					if (x_q[dcmd.idx] && !row_nz && !p_valid_q)
						p_valid_q <= 1'b1;
				end
				OP_UPDATE: begin
					// store at the free leading bit, clear that bit in higher rows
					if (p_valid_q) begin
						if (dcmd.idx == p_q)
							rows_q[dcmd.idx] <= x_q;
						else if (dcmd.idx > p_q && row_sel[p_q])
							rows_q[dcmd.idx] <= row_sel ^ x_q;
					end
				end
				OP_COMMIT: begin
					if (p_valid_q)
						rank_q <= rank_q + RANK_W'(1);
					else if (dep_q < DEP_SAT)
						dep_q <= dep_q + DEP_W'(1);
				end
				default: begin
					cmd_q <= cmd_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (dcmd.op)
			OP_LOAD: begin
				x_q   <= (cmd_in == CMD_INSERT || cmd_in == CMD_CONTAINS) ? value : '0;
				k_q   <= k_eff;
				oor_q <= |(k_eff & ~rank_mask);
			end
			OP_REDUCE: begin
				if (x_q[dcmd.idx] && row_nz)
					x_q <= x_q ^ row_sel;
				else if (x_q[dcmd.idx] && !p_valid_q)
					p_q <= dcmd.idx;
			end
			OP_MAX: begin
				if (!x_q[dcmd.idx])
					x_q <= x_q ^ row_sel;
			end
			OP_KTH: begin
				if (row_nz) begin
					if (k_q[0])
						x_q <= x_q ^ row_sel;
					k_q <= k_q >> 1;
				end
			end
			OP_EMIT: begin
				ans_q  <= ans_d;
				flag_q <= flag_d;
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign answer       = $signed(ans_q);
	assign flag         = flag_q;

endmodule

### rtl/core/xor_linear_basis_engine.sv
// Fully reduced GF(2) basis engine: one command beat in, one result beat out.
// Insert makes a reduce pass and a row update pass of 30 steps each over the
// single row read port, then a commit; contains makes the reduce pass only, max
// and kth one pass of 30 steps each, and unknown commands go straight to the
// result. One item at a time; the next beat is taken the cycle after the result
// enters the output register.
// Async reset clears all basis rows, rank, dependent count and output valid.

module xor_linear_basis_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // value[29:0], index[60:30], zero pad
	input  logic [2:0]  s_tuser,   // command[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // answer[30:0], flag[31]
);
	import xlb_pkg::*;

	dp_cmd_t               dcmd;
	dp_sts_t               sts;
	logic signed [K_W-1:0] answer;
	logic                  flag;

	xlb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.command  (s_tuser),
		.sts      (sts),
		.dcmd     (dcmd)
	);

	xlb_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.dcmd      (dcmd),
		.sts       (sts),
		.command   (s_tuser),
		.value     (s_tdata[BITS-1:0]),
		.index     (s_tdata[BITS+K_W-1:BITS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.answer    (answer),
		.flag      (flag)
	);

	assign m_tdata = {flag, answer};

endmodule
